// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/sha1bsh_pkg.sv
// Package with the constants, codes and round functions of the SHA-1 stream hasher.
`timescale 1ns / 1ps

package sha1bsh_pkg;

   localparam int WORD_W       = 32;
   localparam int DIGEST_WORDS = 5;
   localparam int INDEX_W      = 3;
   localparam int ROUND_W      = 7;
   localparam int FILL_W       = 6;
   localparam int LEN_W        = 64;

   localparam logic [INDEX_W-1:0] LAST_INDEX = 3'd4;
   localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
   localparam logic [FILL_W-1:0]  FILL_LAST  = 6'd63;
   localparam logic [FILL_W-1:0]  FILL_LEN   = 6'd56;
   localparam logic [7:0]         PAD_MARK   = 8'h80;

   localparam logic [1:0] ACT_APPEND        = 2'd0;
   localparam logic [1:0] ACT_APPEND_FINISH = 2'd1;
   localparam logic [1:0] ACT_FINISH        = 2'd2;

   function automatic logic [WORD_W-1:0] init_word(input logic [INDEX_W-1:0] idx);
      logic [WORD_W-1:0] v;
      case (idx)
         3'd0:    v = 32'h67452301;
         3'd1:    v = 32'hEFCDAB89;
         3'd2:    v = 32'h98BADCFE;
         3'd3:    v = 32'h10325476;
         default: v = 32'hC3D2E1F0;
      endcase
      return v;
   endfunction

   function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] rnd);
      logic [WORD_W-1:0] k;
      if (rnd < 7'd20) begin
         k = 32'h5A827999;
      end else if (rnd < 7'd40) begin
         k = 32'h6ED9EBA1;
      end else if (rnd < 7'd60) begin
         k = 32'h8F1BBCDC;
      end else begin
         k = 32'hCA62C1D6;
      end
      return k;
   endfunction

   function automatic logic [WORD_W-1:0] round_f(input logic [ROUND_W-1:0] rnd,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] d);
      logic [WORD_W-1:0] f;
      if (rnd < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if ((rnd >= 7'd40) && (rnd < 7'd60)) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

endpackage

// File: hdl/sha1_byte_stream_hasher_top.sv
// SHA-1 byte stream hasher: byte intake, padding sequencer and one shared round unit.
`timescale 1ns / 1ps

// Message bytes are taken one per transaction into a 512-bit block shift register. The
// 64th byte of a block starts the compression: the round unit does one of the 80
// rounds per cycle, and a fold step then adds the result into the chaining words. A
// finish pushes the 0x80 marker, zero fill and the 64-bit big-endian length one byte a
// cycle through the same intake path, with a second compression when fewer than nine
// bytes are left, runs the last compression, and then offers the five digest words,
// one per transaction, index 0 first. The block takes no new byte while it
// compresses, pads or presents the digest; after the fifth word it is ready for the
// next message.
module sha1_byte_stream_hasher_top
   import sha1bsh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [7:0]          req_data_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WORD_W-1:0]   rsp_digest_word,
   output logic [INDEX_W-1:0]  rsp_word_index,
   output logic                rsp_last_word
);

   typedef enum logic [2:0] {ST_IDLE, ST_ROUND, ST_FOLD, ST_PAD, ST_EMIT} state_type;

   state_type            state_ff, state_in;
   logic [511:0]         blk_ff, blk_in;
   logic [WORD_W-1:0]    h_ff [DIGEST_WORDS];
   logic [WORD_W-1:0]    h_in [DIGEST_WORDS];
   logic [WORD_W-1:0]    a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [WORD_W-1:0]    a_in, b_in, c_in, d_in, e_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [LEN_W-1:0]     bit_total_ff, bit_total_in;
   logic [ROUND_W-1:0]   rnd_ff, rnd_in;
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic                 finish_ff, finish_in;
   logic                 mark_ff, mark_in;
   logic                 pad_len_ff, pad_len_in;

   logic                 push_en;
   logic [7:0]           push_byte;
   logic                 len_now;
   logic [7:0]           len_byte;
   logic [7:0]           pad_byte;
   logic [WORD_W-1:0]    sched_mix;
   logic [WORD_W-1:0]    sched_word;
   logic [WORD_W-1:0]    round_sum;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_digest_word = h_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == LAST_INDEX);

   // The schedule word for round t+16 comes from the taps t+13, t+8, t+2 and t.
   assign sched_mix  = blk_ff[95:64] ^ blk_ff[255:224] ^ blk_ff[447:416] ^ blk_ff[511:480];
   assign sched_word = {sched_mix[WORD_W-2:0], sched_mix[WORD_W-1]};
   assign round_sum  = {a_ff[WORD_W-6:0], a_ff[WORD_W-1:WORD_W-5]}
                       + round_f(rnd_ff, b_ff, c_ff, d_ff) + e_ff
                       + blk_ff[511:480] + round_k(rnd_ff);

   // The length bytes fill positions 56 to 63 of the last block, most significant first.
   assign len_now  = pad_len_ff | (mark_ff & (fill_ff == FILL_LEN));
   assign len_byte = 8'(bit_total_ff >> {~fill_ff[2:0], 3'b000});
   assign pad_byte = len_now ? len_byte : (mark_ff ? 8'h00 : PAD_MARK);

   always_comb begin
      state_in     = state_ff;
      blk_in       = blk_ff;
      h_in         = h_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      fill_in      = fill_ff;
      bit_total_in = bit_total_ff;
      rnd_in       = rnd_ff;
      idx_in       = idx_ff;
      finish_in    = finish_ff;
      mark_in      = mark_ff;
      pad_len_in   = pad_len_ff;
      push_en      = 1'b0;
      push_byte    = req_data_byte;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_action)
                  ACT_APPEND, ACT_APPEND_FINISH: begin
                     push_en      = 1'b1;
                     bit_total_in = bit_total_ff + LEN_W'(8);
                     finish_in    = (req_action == ACT_APPEND_FINISH);
                     if ((fill_ff != FILL_LAST) && (req_action == ACT_APPEND_FINISH)) begin
                        state_in = ST_PAD;
                     end
                  end
                  ACT_FINISH: begin
                     finish_in = 1'b1;
                     state_in  = ST_PAD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PAD: begin
            push_en    = 1'b1;
            push_byte  = pad_byte;
            mark_in    = 1'b1;
            pad_len_in = len_now;
         end
         ST_ROUND: begin
            a_in   = round_sum;
            b_in   = a_ff;
            c_in   = {b_ff[1:0], b_ff[WORD_W-1:2]};
            d_in   = c_ff;
            e_in   = d_ff;
            blk_in = {blk_ff[479:0], sched_word};
            rnd_in = rnd_ff + ROUND_W'(1);
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            h_in[0] = h_ff[0] + a_ff;
            h_in[1] = h_ff[1] + b_ff;
            h_in[2] = h_ff[2] + c_ff;
            h_in[3] = h_ff[3] + d_ff;
            h_in[4] = h_ff[4] + e_ff;
            if (!finish_ff) begin
               state_in = ST_IDLE;
            end else if (pad_len_ff) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (idx_ff == LAST_INDEX) begin
                  for (int k = 0; k < DIGEST_WORDS; k++) begin
                     h_in[k] = init_word(INDEX_W'(k));
                  end
                  bit_total_in = '0;
                  finish_in    = 1'b0;
                  mark_in      = 1'b0;
                  pad_len_in   = 1'b0;
                  idx_in       = '0;
                  state_in     = ST_IDLE;
               end else begin
                  idx_in = idx_ff + INDEX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A byte shifts in at the bottom; the 64th byte of a block starts the rounds.
      if (push_en) begin
         blk_in  = {blk_ff[503:0], push_byte};
         fill_in = fill_ff + FILL_W'(1);
         if (fill_ff == FILL_LAST) begin
            a_in     = h_ff[0];
            b_in     = h_ff[1];
            c_in     = h_ff[2];
            d_in     = h_ff[3];
            e_in     = h_ff[4];
            rnd_in   = '0;
            state_in = ST_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         for (int k = 0; k < DIGEST_WORDS; k++) begin
            h_ff[k] <= init_word(INDEX_W'(k));
         end
         fill_ff      <= '0;
         bit_total_ff <= '0;
         rnd_ff       <= '0;
         idx_ff       <= '0;
         finish_ff    <= 1'b0;
         mark_ff      <= 1'b0;
         pad_len_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         h_ff         <= h_in;
         fill_ff      <= fill_in;
         bit_total_ff <= bit_total_in;
         rnd_ff       <= rnd_in;
         idx_ff       <= idx_in;
         finish_ff    <= finish_in;
         mark_ff      <= mark_in;
         pad_len_ff   <= pad_len_in;
      end
   end

endmodule

// File: hdl/sha1bsh_checker.sv
// Port-level checker for the SHA-1 stream hasher and the bind that attaches it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha1bsh_checker
   import sha1bsh_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [1:0]          req_action,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [INDEX_W-1:0]  rsp_word_index,
   input logic                rsp_last_word
);

   // No byte is taken while the digest is on offer.
   `ASSERT_ALWAYS(a_no_intake_during_digest, clock, reset, !(req_ready && rsp_valid), "byte intake open while digest is offered")

   `ASSERT_IMPLY(a_last_flag, clock, reset, rsp_valid, rsp_last_word == (rsp_word_index == LAST_INDEX), "last word flag does not match the word index")

   // Digest words follow one another without a gap in between.
   `ASSERT_NEXT(a_word_order, clock, reset, rsp_valid && rsp_ready && !rsp_last_word, rsp_valid && (rsp_word_index == INDEX_W'($past(rsp_word_index) + 3'd1)), "digest words out of order")

   `ASSERT_NEXT(a_ready_after_digest, clock, reset, rsp_valid && rsp_ready && rsp_last_word, req_ready && !rsp_valid, "not ready for a new message after the last digest word")

   `ASSERT_NEXT(a_busy_after_finish, clock, reset, req_valid && req_ready && (req_action == ACT_FINISH), !req_ready, "finish transaction did not start padding")

endmodule

bind sha1_byte_stream_hasher_top sha1bsh_checker u_sha1bsh_checker (.*);

// File: test/sha1_byte_stream_hasher_top_tb.sv
// Self-checking testbench for the SHA-1 byte stream hasher, with its own digest predictor.
`timescale 1ns / 1ps

module sha1_byte_stream_hasher_top_tb;
   import sha1bsh_pkg::*;

   localparam logic [1:0]   ACT_UNUSED   = 2'd3;
   localparam logic [159:0] SHA_IV       = 160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
   localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
   localparam logic [159:0] ABC_DIGEST   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;
   localparam int           HOLD_CYCLES  = 600;
   localparam int           PHASE_ITEMS  = 20;

   typedef struct packed {
      logic [WORD_W-1:0]  word;
      logic [INDEX_W-1:0] index;
      logic               last;
   } digest_word_type;

   typedef struct packed {
      logic [1:0]   act;
      logic [7:0]   byt;
      bit           typed;
      logic [159:0] digest;
   } stim_row_type;

   // Rows with a typed digest are compared against that value instead of the predictor.
   stim_row_type stim_rows [0:11] = '{
      '{ACT_FINISH,        8'h00, 1'b1, EMPTY_DIGEST},
      '{ACT_UNUSED,        8'hFF, 1'b0, 160'd0},
      '{ACT_APPEND,        8'h61, 1'b0, 160'd0},
      '{ACT_APPEND,        8'h62, 1'b0, 160'd0},
      '{ACT_APPEND_FINISH, 8'h63, 1'b1, ABC_DIGEST},
      '{ACT_APPEND_FINISH, 8'h00, 1'b0, 160'd0},
      '{ACT_APPEND_FINISH, 8'hFF, 1'b0, 160'd0},
      '{ACT_UNUSED,        8'h00, 1'b0, 160'd0},
      '{ACT_FINISH,        8'hFF, 1'b1, EMPTY_DIGEST},
      '{ACT_APPEND,        8'hFF, 1'b0, 160'd0},
      '{ACT_APPEND,        8'h00, 1'b0, 160'd0},
      '{ACT_FINISH,        8'hA5, 1'b0, 160'd0}
   };

   logic                clock;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_ready;
   logic [1:0]          req_action    = ACT_APPEND;
   logic [7:0]          req_data_byte = 8'h00;
   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   logic [WORD_W-1:0]   rsp_digest_word;
   logic [INDEX_W-1:0]  rsp_word_index;
   logic                rsp_last_word;

   // Predictor state.
   logic [31:0]  sha_chain [0:4];
   logic [7:0]   msg_block [0:63];
   int           block_fill;
   logic [63:0]  msg_bits;

   digest_word_type pending_words [$];
   digest_word_type oldest_word;
   int           error_count   = 0;
   int           items_sent    = 0;
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;
   int           hold_ticket   = 0;
   int           hold_served   = 0;
   int           hold_left     = 0;

   sha1_byte_stream_hasher_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void restart_message();
      int k;
      for (k = 0; k < 5; k++) begin
         sha_chain[k] = SHA_IV[159-32*k -: 32];
      end
      block_fill = 0;
      msg_bits   = 64'd0;
   endfunction

   function automatic void compress_block();
      logic [31:0] w [0:79];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      int          i;
      for (i = 0; i < 16; i++) begin
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      end
      for (i = 16; i < 80; i++) begin
         x    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
         w[i] = {x[30:0], x[31]};
      end
      a = sha_chain[0];
      b = sha_chain[1];
      c = sha_chain[2];
      d = sha_chain[3];
      e = sha_chain[4];
      for (i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
         end
         t = {a[26:0], a[31:27]} + f + e + w[i] + k;
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      sha_chain[0] += a;
      sha_chain[1] += b;
      sha_chain[2] += c;
      sha_chain[3] += d;
      sha_chain[4] += e;
      block_fill = 0;
   endfunction

   // Advances the predicted message state by one transaction; a finish yields the digest.
   function automatic void predict_item(input logic [1:0] act, input logic [7:0] byt,
                                        output bit done, output logic [159:0] digest);
      int i;
      done   = 1'b0;
      digest = '0;
      if (act == ACT_UNUSED) return;
      if (act == ACT_APPEND || act == ACT_APPEND_FINISH) begin
         msg_block[block_fill] = byt;
         block_fill++;
         msg_bits += 64'd8;
         if (block_fill == 64) compress_block();
      end
      if (act == ACT_APPEND) return;
      msg_block[block_fill] = PAD_MARK;
      block_fill++;
      // Fewer than eight bytes left for the length, so the padding spills into a second block.
      if (block_fill > 56) begin
         while (block_fill < 64) begin
            msg_block[block_fill] = 8'h00;
            block_fill++;
         end
         compress_block();
      end
      while (block_fill < 56) begin
         msg_block[block_fill] = 8'h00;
         block_fill++;
      end
      for (i = 0; i < 8; i++) begin
         msg_block[56+i] = msg_bits[63-8*i -: 8];
      end
      compress_block();
      digest = {sha_chain[0], sha_chain[1], sha_chain[2], sha_chain[3], sha_chain[4]};
      done   = 1'b1;
      restart_message();
   endfunction

   task automatic send_item(input logic [1:0] act, input logic [7:0] byt,
                            input bit typed, input logic [159:0] typed_digest);
      logic [159:0] digest;
      bit           done;
      int           k;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_data_byte <= byt;
      do @(posedge clock); while (!req_ready);
      predict_item(act, byt, done, digest);
      if (done) begin
         if (typed) digest = typed_digest;
         for (k = 0; k < 5; k++) begin
            pending_words.push_back('{word: digest[159-32*k -: 32], index: 3'(k),
                                      last: (k == 4)});
         end
      end
      if (act != ACT_UNUSED) items_sent++;
   endtask

   task automatic send_message(input int len);
      bit         end_with_byte;
      logic [1:0] act;
      int         i;
      end_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 15) == 0) send_item(ACT_UNUSED, 8'($urandom), 1'b0, '0);
         act = (end_with_byte && i == len - 1) ? ACT_APPEND_FINISH : ACT_APPEND;
         send_item(act, 8'($urandom), 1'b0, '0);
      end
      if (!end_with_byte) send_item(ACT_FINISH, 8'($urandom), 1'b0, '0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0);
   endtask

   // Receiver: random stalls, or one long hold-off whenever a new one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_served != hold_ticket) begin
         hold_served <= hold_ticket;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("Unexpected digest word: word %h index %0d last %b",
                        rsp_digest_word, rsp_word_index, rsp_last_word);
            end
         end else begin
            oldest_word = pending_words.pop_front();
            if (rsp_digest_word !== oldest_word.word || rsp_word_index !== oldest_word.index
                || rsp_last_word !== oldest_word.last) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("Digest mismatch: expected word %h index %0d last %b, got %h %0d %b",
                           oldest_word.word, oldest_word.index, oldest_word.last,
                           rsp_digest_word, rsp_word_index, rsp_last_word);
               end
            end
         end
      end
   end

   initial begin
      int row;
      int phase;
      int phase_start;
      int len;
      restart_message();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < 12; row++) begin
         send_item(stim_rows[row].act, stim_rows[row].byt, stim_rows[row].typed,
                   stim_rows[row].digest);
      end
      wait_drained();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
               // Hold the receiver off for a long stretch so the input side backs up.
               hold_ticket <= hold_ticket + 1;
            end
            1: begin
               send_idle_pct = 54;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 54;
            end
            default: begin
               send_idle_pct = 17;
               rsp_stall_pct = 17;
            end
         endcase
         phase_start = items_sent;
         // The first three phases open with a long message that lands on a block or
         // padding boundary.
         case (phase)
            0:       send_message(64);
            1:       send_message(56);
            2:       send_message(55);
            default: send_message($urandom_range(0, 12));
         endcase
         while (items_sent - phase_start < PHASE_ITEMS) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 70) : $urandom_range(0, 12);
            send_message(len);
         end
         wait_drained();
      end

      repeat (300) @(posedge clock);
      if (error_count == 0 && pending_words.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
